// File: rtl/mono_framebuffer_line_glyph_draw_defines.svh
// Assertion macros used by the framebuffer drawing top level.
`ifndef MONO_FRAMEBUFFER_LINE_GLYPH_DRAW_DEFINES_SVH
`define MONO_FRAMEBUFFER_LINE_GLYPH_DRAW_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define MFB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MFB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mfb_pkg.sv
// Types, constants and font tables for the framebuffer drawing engine.
package mfb_pkg;

  // Display geometry
  localparam int COLUMNS     = 128;
  localparam int ROWS        = 64;
  localparam int PAGE_HEIGHT = 8;
  localparam int NPAGES      = ROWS / PAGE_HEIGHT;
  localparam int STORE_BYTES = COLUMNS * NPAGES;

  localparam int X_W    = $clog2(COLUMNS);
  localparam int Y_W    = $clog2(ROWS);
  localparam int BIT_W  = $clog2(PAGE_HEIGHT);
  localparam int PAGE_W = $clog2(NPAGES);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int BYTE_W = PAGE_HEIGHT;
  localparam int E_W    = X_W + 3;

  localparam int FUNC_W  = 3;
  localparam int GLYPH_W = 4;

  // Glyph walk: 4 columns, 6 rows each
  localparam logic [1:0] GLYPH_COL_LAST = 2'd3;
  localparam logic [2:0] GLYPH_ROW_LAST = 3'd5;

  // Stream payload widths
  localparam int IN_BITS   = FUNC_W + 2 * X_W + 2 * Y_W + GLYPH_W + PAGE_W + X_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 3'd0,
    FN_POINT = 3'd1,
    FN_LINE  = 3'd2,
    FN_GLYPH = 3'd3,
    FN_READ  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_RWAIT,
    ST_FIN
  } top_state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_POINT,
    G_LINE,
    G_GLYPH
  } gen_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [X_W-1:0]     x_start;
    logic [Y_W-1:0]     y_start;
    logic [X_W-1:0]     x_end;
    logic [Y_W-1:0]     y_end;
    logic [GLYPH_W-1:0] glyph_index;
  } draw_cmd_t;

  typedef struct packed {
    logic           valid;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } pixel_t;

  // Font cells: high nibble upper row, low nibble lower row, bit 3 leftmost.
  // Entry 15 is blank so an unused index draws nothing.
  localparam logic [7:0] FONT_HI [16] = '{
    8'h69, 8'h26, 8'h69, 8'h79, 8'h26, 8'hE8, 8'h68, 8'hF1,
    8'h69, 8'h69, 8'h89, 8'h00, 8'h78, 8'hE9, 8'h78, 8'h00
  };
  localparam logic [7:0] FONT_MD [16] = '{
    8'h99, 8'h22, 8'h16, 8'h21, 8'hAF, 8'hE1, 8'hE9, 8'h12,
    8'h69, 8'h97, 8'hAC, 8'h00, 8'h8E, 8'h9E, 8'h61, 8'h00
  };
  localparam logic [7:0] FONT_LO [16] = '{
    8'h96, 8'h2F, 8'h8F, 8'h96, 8'h22, 8'h1E, 8'h96, 8'h48,
    8'h96, 8'h16, 8'hA9, 8'h66, 8'h88, 8'h88, 8'h1E, 8'h00
  };

  // Pixel of glyph g at column col (0 left) and row sub (0 bottom, 5 top)
  function automatic logic glyph_bit(input logic [GLYPH_W-1:0] g,
                                     input logic [1:0] col,
                                     input logic [2:0] sub);
    logic [7:0] row_pair;
    logic [2:0] idx;
    unique case (sub[2:1])
      2'd0:    row_pair = FONT_LO[g];
      2'd1:    row_pair = FONT_MD[g];
      default: row_pair = FONT_HI[g];
    endcase
    idx = {sub[0], ~col};
    return row_pair[idx];
  endfunction

endpackage

// File: rtl/mfb_pixel_gen.sv
// Pixel generator: walks a point, a Bresenham line or a glyph, one pixel per cycle.
module mfb_pixel_gen
  import mfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  draw_cmd_t cmd,
  output pixel_t    pix,
  output logic      busy
);

  gen_state_t gst_r, gst_nxt;

  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [E_W-1:0]     e_r;
  logic [X_W-1:0]     maj_r;
  logic [X_W-1:0]     mnr_r;
  logic               steep_r;
  logic               sxneg_r;
  logic               syneg_r;
  logic [X_W-1:0]     cnt_r;
  logic [X_W-1:0]     lastc_r;
  logic [1:0]         col_r;
  logic [2:0]         sub_r;
  logic [GLYPH_W-1:0] glyph_r;

  // Line setup from the incoming command
  logic [X_W-1:0] adx, ady, maj_s, mnr_s;
  logic [E_W-1:0] e0;
  logic           steep_s;

  always_comb begin
    adx = (cmd.x_end >= cmd.x_start) ? (cmd.x_end - cmd.x_start)
                                     : (cmd.x_start - cmd.x_end);
    ady = (cmd.y_end >= cmd.y_start) ? X_W'(cmd.y_end - cmd.y_start)
                                     : X_W'(cmd.y_start - cmd.y_end);
    steep_s = ady > adx;
    maj_s   = steep_s ? ady : adx;
    mnr_s   = steep_s ? adx : ady;
    e0      = {2'b00, mnr_s, 1'b0} - {3'b000, maj_s};
  end

  // Bresenham step
  logic           minor_step, x_adv, y_adv;
  logic [X_W-1:0] x_step, sx;
  logic [Y_W-1:0] y_step, sy;
  logic [E_W-1:0] e_step;

  always_comb begin
    minor_step = ~e_r[E_W-1];
    x_adv      = steep_r ? minor_step : 1'b1;
    y_adv      = steep_r ? 1'b1 : minor_step;
    sx         = sxneg_r ? {X_W{1'b1}} : X_W'(1);
    sy         = syneg_r ? {Y_W{1'b1}} : Y_W'(1);
    x_step     = x_adv ? (x_r + sx) : x_r;
    y_step     = y_adv ? (y_r + sy) : y_r;
    e_step     = e_r + {2'b00, mnr_r, 1'b0}
               - (minor_step ? {2'b00, maj_r, 1'b0} : {E_W{1'b0}});
  end

  // Next state and pixel output
  always_comb begin
    gst_nxt   = gst_r;
    pix.valid = 1'b0;
    pix.x     = x_r;
    pix.y     = y_r;
    unique case (gst_r)
      G_IDLE: begin
        if (start) begin
          unique case (cmd.func)
            FN_POINT: gst_nxt = G_POINT;
            FN_LINE:  gst_nxt = (maj_s != '0) ? G_LINE : G_IDLE;
            FN_GLYPH: gst_nxt = G_GLYPH;
            default:  gst_nxt = G_IDLE;
          endcase
        end
      end
      G_POINT: begin
        pix.valid = 1'b1;
        gst_nxt   = G_IDLE;
      end
      G_LINE: begin
        pix.valid = 1'b1;
        if (cnt_r == lastc_r) gst_nxt = G_IDLE;
      end
      G_GLYPH: begin
        pix.valid = glyph_bit(glyph_r, col_r, sub_r);
        pix.x     = x_r + X_W'(col_r);
        pix.y     = y_r - Y_W'(sub_r);
        if (col_r == GLYPH_COL_LAST && sub_r == GLYPH_ROW_LAST) gst_nxt = G_IDLE;
      end
      default: gst_nxt = G_IDLE;
    endcase
  end

  assign busy = (gst_r != G_IDLE);

  // Hold the walk state
  always_ff @(posedge clk) begin
    if (!rst_n) gst_r <= G_IDLE;
    else        gst_r <= gst_nxt;
  end

  // Load on start, advance while walking
  always_ff @(posedge clk) begin
    if (start && gst_r == G_IDLE) begin
      x_r     <= cmd.x_start;
      y_r     <= cmd.y_start;
      e_r     <= e0;
      maj_r   <= maj_s;
      mnr_r   <= mnr_s;
      steep_r <= steep_s;
      sxneg_r <= cmd.x_end < cmd.x_start;
      syneg_r <= cmd.y_end < cmd.y_start;
      cnt_r   <= '0;
      lastc_r <= maj_s - X_W'(1);
      col_r   <= '0;
      sub_r   <= '0;
      glyph_r <= cmd.glyph_index;
    end else if (gst_r == G_LINE) begin
      x_r   <= x_step;
      y_r   <= y_step;
      e_r   <= e_step;
      cnt_r <= cnt_r + X_W'(1);
    end else if (gst_r == G_GLYPH) begin
      if (sub_r == GLYPH_ROW_LAST) begin
        sub_r <= '0;
        col_r <= col_r + 2'd1;
      end else begin
        sub_r <= sub_r + 3'd1;
      end
    end
  end

endmodule

// File: rtl/mono_framebuffer_line_glyph_draw.sv
// Top level: command sequencer, frame store and read-modify-write pixel path.
//
//  channel | ports                         | payload (lowest bit first)
//  --------+-------------------------------+--------------------------------------
//  input   | in_tvalid in_tready in_tdata  | func, x_start, y_start, x_end, y_end,
//          |                               | glyph_index, read_page, read_column
//  result  | out_tvalid out_tready out_tdata | read_byte
//
// The single write port of the frame store sets the pace at one byte per cycle.
// Pixels go through a two-stage read-modify-write with forwarding of the last write.
// After reset the store is zeroed by a pass over every byte; in_tready stays low meanwhile.
// A result still waiting in the output register holds the next command at its finish
// step; the input opens again once that result has moved out.
`include "mono_framebuffer_line_glyph_draw_defines.svh"

module mono_framebuffer_line_glyph_draw
  import mfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // func[2:0], x_start[9:3], y_start[15:10], x_end[22:16], y_end[28:23],
  // glyph_index[32:29], read_page[35:33], read_column[42:36], zero fill above
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // read_byte[7:0]
  output logic [BYTE_W-1:0]    out_tdata
);

  // Unpack the input transaction
  localparam int XS_LO = FUNC_W;
  localparam int YS_LO = XS_LO + X_W;
  localparam int XE_LO = YS_LO + Y_W;
  localparam int YE_LO = XE_LO + X_W;
  localparam int GI_LO = YE_LO + Y_W;
  localparam int RP_LO = GI_LO + GLYPH_W;
  localparam int RC_LO = RP_LO + PAGE_W;

  draw_cmd_t         cmd;
  logic [PAGE_W-1:0] in_read_page;
  logic [X_W-1:0]    in_read_column;

  assign cmd.func        = in_tdata[FUNC_W-1:0];
  assign cmd.x_start     = in_tdata[XS_LO +: X_W];
  assign cmd.y_start     = in_tdata[YS_LO +: Y_W];
  assign cmd.x_end       = in_tdata[XE_LO +: X_W];
  assign cmd.y_end       = in_tdata[YE_LO +: Y_W];
  assign cmd.glyph_index = in_tdata[GI_LO +: GLYPH_W];
  assign in_read_page    = in_tdata[RP_LO +: PAGE_W];
  assign in_read_column  = in_tdata[RC_LO +: X_W];

  top_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [BYTE_W-1:0] res_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;

  logic              s2_valid_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [BIT_W-1:0]  s2_bit_r;
  logic              lw_valid_r;
  logic [ADDR_W-1:0] lw_addr_r;
  logic [BYTE_W-1:0] lw_data_r;

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] mem_rdata_r;

  logic              accept, gen_start, gen_busy, out_load, clearing, clr_last;
  pixel_t            pix;

  mfb_pixel_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gen_start),
    .cmd   (cmd),
    .pix   (pix),
    .busy  (gen_busy)
  );

  assign accept   = in_tvalid && in_tready;
  assign clearing = (state_r == ST_INIT) || (state_r == ST_CLEAR);
  assign clr_last = (clr_cnt_r == ADDR_W'(STORE_BYTES - 1));

  // Sequence commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    gen_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (cmd.func)
            FN_CLEAR: state_nxt = ST_CLEAR;
            FN_POINT, FN_LINE, FN_GLYPH: begin
              state_nxt = ST_DRAW;
              gen_start = 1'b1;
            end
            FN_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_FIN;
      end
      ST_DRAW: begin
        if (!gen_busy) state_nxt = ST_FIN;
      end
      ST_READ:  state_nxt = ST_RWAIT;
      ST_RWAIT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (!s2_valid_r && (!out_valid_r || out_tready)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      s2_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s2_valid_r <= pix.valid;
      lw_valid_r <= s2_valid_r;
      if (clearing) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Capture read address and result byte
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr_r <= {in_read_page, in_read_column};
      res_r     <= '0;
    end else if (state_r == ST_RWAIT) begin
      res_r <= mem_rdata_r;
    end
    if (out_load) out_data_r <= res_r;
  end

  // Read-modify-write path with forwarding of the previous write
  logic [ADDR_W-1:0] pix_addr, mem_raddr, mem_waddr;
  logic [BYTE_W-1:0] rmw_base, mem_wdata;
  logic              mem_we;

  always_comb begin
    pix_addr  = {pix.y[Y_W-1:BIT_W], pix.x};
    mem_raddr = (state_r == ST_READ) ? rd_addr_r : pix_addr;
    rmw_base  = (lw_valid_r && lw_addr_r == s2_addr_r) ? lw_data_r : mem_rdata_r;
    mem_we    = clearing || s2_valid_r;
    mem_waddr = clearing ? clr_cnt_r : s2_addr_r;
    mem_wdata = clearing ? '0 : (rmw_base | (BYTE_W'(1) << s2_bit_r));
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= pix_addr;
    s2_bit_r  <= pix.y[BIT_W-1:0];
    lw_addr_r <= s2_addr_r;
    lw_data_r <= mem_wdata;
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `MFB_ASSERT_IMP(a_accept_drained, accept, !s2_valid_r && !gen_busy, "accept with pixels in flight")
  `MFB_ASSERT_IMP(a_clear_exclusive, clearing, !s2_valid_r && !pix.valid, "pixel write during clear")
  `MFB_ASSERT_NXT(a_result_loaded, out_load, out_valid_r && out_data_r == $past(res_r), "result lost")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the framebuffer line and glyph drawing engine.
module tb_top
  import mfb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HIGH       = 6;
  localparam int CLK_LOW        = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_ITEMS     = 24;
  localparam int SETTLE_CYCLES  = 200;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  localparam logic [FUNC_W-1:0]  FN_LAST_CODE = '1;
  localparam int                 GLYPH_COUNT  = 15;
  localparam logic [GLYPH_W-1:0] GLYPH_NONE   = '1;

  // Font cells, bottom pair of rows first; high nibble is the upper row, bit 3 leftmost
  localparam bit [7:0] GLYPH_BOT [GLYPH_COUNT] = '{
    8'h96, 8'h2F, 8'h8F, 8'h96, 8'h22, 8'h1E, 8'h96, 8'h48,
    8'h96, 8'h16, 8'hA9, 8'h66, 8'h88, 8'h88, 8'h1E
  };
  localparam bit [7:0] GLYPH_MID [GLYPH_COUNT] = '{
    8'h99, 8'h22, 8'h16, 8'h21, 8'hAF, 8'hE1, 8'hE9, 8'h12,
    8'h69, 8'h97, 8'hAC, 8'h00, 8'h8E, 8'h9E, 8'h61
  };
  localparam bit [7:0] GLYPH_TOP [GLYPH_COUNT] = '{
    8'h69, 8'h26, 8'h69, 8'h79, 8'h26, 8'hE8, 8'h68, 8'hF1,
    8'h69, 8'h69, 8'h89, 8'h00, 8'h78, 8'hE9, 8'h78
  };

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [X_W-1:0]     xs;
    logic [Y_W-1:0]     ys;
    logic [X_W-1:0]     xe;
    logic [Y_W-1:0]     ye;
    logic [GLYPH_W-1:0] glyph;
    logic [PAGE_W-1:0]  page;
    logic [X_W-1:0]     col;
  } gfx_cmd_t;

  // Shadow frame store and queue of bytes the block must return
  class frame_scoreboard;
    bit [BYTE_W-1:0] frame [STORE_BYTES];
    bit [BYTE_W-1:0] expected_bytes [$];
    int              errors;

    function void set_pixel(int x, int y);
      int cx;
      int cy;
      cx = x % COLUMNS;
      cy = y % ROWS;
      if (cx < 0) cx += COLUMNS;
      if (cy < 0) cy += ROWS;
      frame[(cy / PAGE_HEIGHT) * COLUMNS + cx][cy % PAGE_HEIGHT] = 1'b1;
    endfunction

    // Walk the major axis; the end pixel is never set
    function void trace_line(int x1, int y1, int x2, int y2);
      int dx, dy, sx, sy, x, y, err, tmp;
      bit steep;
      dx = x2 - x1;
      dy = y2 - y1;
      sx = 1;
      sy = 1;
      x = x1;
      y = y1;
      steep = 1'b0;
      if (dx < 0) begin
        sx = -1;
        dx = -dx;
      end
      if (dy < 0) begin
        sy = -1;
        dy = -dy;
      end
      if (dy > dx) begin
        tmp = dx;
        dx = dy;
        dy = tmp;
        steep = 1'b1;
      end
      err = 2 * dy - dx;
      for (int n = 0; n < dx; n++) begin
        set_pixel(x, y);
        if (err >= 0) begin
          if (steep) x += sx;
          else y += sy;
          err -= 2 * dx;
        end
        if (steep) y += sy;
        else x += sx;
        err += 2 * dy;
      end
    endfunction

    // Rows run upward on screen, so y decreases with each font row
    function void stamp_glyph(int g, int xl, int yb);
      bit [7:0] rows [3];
      bit [7:0] mask;
      if (g >= GLYPH_COUNT) return;
      rows[0] = GLYPH_BOT[g];
      rows[1] = GLYPH_MID[g];
      rows[2] = GLYPH_TOP[g];
      mask = 8'h88;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          if ((rows[r] & mask & 8'h0F) != 0) set_pixel(xl + c, yb - 2 * r);
          if ((rows[r] & mask & 8'hF0) != 0) set_pixel(xl + c, yb - 2 * r - 1);
        end
        mask = mask >> 1;
      end
    endfunction

    function void note_cmd(gfx_cmd_t c);
      bit [BYTE_W-1:0] rd;
      rd = '0;
      case (c.func)
        FN_CLEAR: foreach (frame[i]) frame[i] = '0;
        FN_POINT: set_pixel(int'(c.xs), int'(c.ys));
        FN_LINE:  trace_line(int'(c.xs), int'(c.ys), int'(c.xe), int'(c.ye));
        FN_GLYPH: stamp_glyph(int'(c.glyph), int'(c.xs), int'(c.ys));
        FN_READ:  rd = frame[(int'(c.page) % NPAGES) * COLUMNS + int'(c.col) % COLUMNS];
        default:  ;
      endcase
      expected_bytes.push_back(rd);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns read_byte mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(bit [BYTE_W-1:0] got);
      bit [BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("got 0x%02h with nothing outstanding", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want)
          report_mismatch($sformatf("got 0x%02h, want 0x%02h", got, want));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BYTE_W-1:0]    out_tdata;

  frame_scoreboard sb;
  int              hold_request;
  int              last_x;
  int              last_y;

  mono_framebuffer_line_glyph_draw dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #CLK_LOW;
    clk = 1'b1;
    #CLK_HIGH;
  end

  // Check every result transaction against the oldest outstanding byte
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata);
  end

  // Receiver: random stall patterns, plus a long hold-off on request
  initial begin
    int       hold_left;
    int       phase_left;
    int       mode;
    bit [15:0] mask;
    out_tready = 1'b0;
    hold_left = 0;
    phase_left = 0;
    mode = 0;
    mask = '1;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 96);
          mask = 16'($urandom);
        end
        phase_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_tready <= mask[0];
            mask = {mask[0], mask[15:1]};
          end
        endcase
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_cmd(gfx_cmd_t c);
    return IN_DATA_W'({c.col, c.page, c.glyph, c.ye, c.xe, c.ys, c.xs, c.func});
  endfunction

  function automatic gfx_cmd_t mk_cmd(logic [FUNC_W-1:0] f, int xs, int ys, int xe, int ye,
                                      int g, int p, int col);
    gfx_cmd_t c;
    c.func = f;
    c.xs = X_W'(xs);
    c.ys = Y_W'(ys);
    c.xe = X_W'(xe);
    c.ye = Y_W'(ye);
    c.glyph = GLYPH_W'(g);
    c.page = PAGE_W'(p);
    c.col = X_W'(col);
    return c;
  endfunction

  // Draw-heavy mix; most lines are short and most reads land near the last drawing
  function automatic gfx_cmd_t random_cmd();
    gfx_cmd_t c;
    int pick;
    int lo;
    int hi;
    c = mk_cmd(FN_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) c.func = FN_CLEAR;
    else if (pick < 17) c.func = FN_POINT;
    else if (pick < 47) c.func = FN_LINE;
    else if (pick < 62) c.func = FN_GLYPH;
    else if (pick < 95) c.func = FN_READ;
    else c.func = FUNC_W'($urandom_range(FN_READ + 1, FN_LAST_CODE));
    if (c.func == FN_LINE && $urandom_range(0, 3) != 0) begin
      lo = (c.xs > 16) ? c.xs - 16 : 0;
      hi = (c.xs < COLUMNS - 17) ? c.xs + 16 : COLUMNS - 1;
      c.xe = X_W'($urandom_range(lo, hi));
      lo = (c.ys > 16) ? c.ys - 16 : 0;
      hi = (c.ys < ROWS - 17) ? c.ys + 16 : ROWS - 1;
      c.ye = Y_W'($urandom_range(lo, hi));
    end
    if (c.func == FN_READ && $urandom_range(0, 9) < 6) begin
      c.page = PAGE_W'(last_y / PAGE_HEIGHT);
      c.col = X_W'(last_x + $urandom_range(0, 3));
    end
    if (c.func == FN_POINT || c.func == FN_LINE || c.func == FN_GLYPH) begin
      last_x = c.xs;
      last_y = c.ys;
    end
    return c;
  endfunction

  // Offer one command and hold it until the block takes it
  task send_cmd(gfx_cmd_t c);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= pack_cmd(c);
    do @(posedge clk); while (!in_tready);
    sb.note_cmd(c);
  endtask

  task idle_input(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int items;
    int burst;
    int pick;
    gfx_cmd_t c;
    sb = new();
    hold_request = 0;
    last_x = 0;
    last_y = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: corners, all commands, wrapping glyph, blank glyph, spare codes
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_POINT, COLUMNS - 1, ROWS - 1, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, NPAGES - 1, COLUMNS - 1));
    send_cmd(mk_cmd(FN_LINE, 10, 10, 10, 10, 0, 0, 0));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 1, 10));
    send_cmd(mk_cmd(FN_LINE, 0, 0, COLUMNS - 1, ROWS - 1, 0, 0, 0));
    send_cmd(mk_cmd(FN_LINE, COLUMNS - 1, ROWS - 1, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_LINE, 5, 60, 9, 2, 0, 0, 0));
    send_cmd(mk_cmd(FN_GLYPH, COLUMNS - 2, 2, 0, 0, 8, 0, 0));
    send_cmd(mk_cmd(FN_GLYPH, 40, 40, 0, 0, GLYPH_NONE, 0, 0));
    send_cmd(mk_cmd(FN_GLYPH, 0, ROWS - 1, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 0, COLUMNS - 1));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, NPAGES - 1, 1));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 5, 40));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 7, 7));
    for (int f = FN_READ + 1; f <= FN_LAST_CODE; f++)
      send_cmd(mk_cmd(FUNC_W'(f), COLUMNS - 1, ROWS - 1, COLUMNS - 1, ROWS - 1, GLYPH_NONE,
                      NPAGES - 1, COLUMNS - 1));
    send_cmd(mk_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(FN_READ, 0, 0, 0, 0, 0, NPAGES - 1, COLUMNS - 1));
    wait_results_drained();

    // Back-pressure: keep offering while results are blocked
    hold_request = HOLD_CYCLES;
    repeat (HOLD_ITEMS) send_cmd(random_cmd());
    wait_results_drained();

    // Random bursts with random gaps and occasional full drains
    items = 0;
    while (items < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        c = random_cmd();
        send_cmd(c);
        items++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) wait_results_drained();
      else if (pick < 60) idle_input($urandom_range(1, 12));
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
